// File: rtl/core/wfcd_pkg.sv
// ----------------------------------------------------------------------------
// wfcd_pkg
// shared types and constants of the wait-for cycle detector
// ----------------------------------------------------------------------------
`default_nettype none

package wfcd_pkg;

	localparam int ID_W = 5;

	// command codes on the input tuser
	typedef enum logic [2:0] {
		CMD_REG   = 3'd0,
		CMD_UNREG = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_LIST  = 3'd3,
		CMD_FIND  = 3'd4,
		CMD_ANY   = 3'd5
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIST,
		ST_WALK,
		ST_EMIT,
		ST_EMIT_LAST,
		ST_SCAN,
		ST_DWALK,
		ST_REPORT
	} state_t;

	typedef enum logic [1:0] {
		TBL_NONE,
		TBL_SET,
		TBL_CLR,
		TBL_WIPE
	} tbl_op_t;

	typedef enum logic [1:0] {
		CUR_HOLD,
		CUR_LOAD_IN,
		CUR_LOAD_IDX,
		CUR_STEP
	} cur_op_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		OUT_EDGE,
		OUT_MEMBER,
		OUT_HEAD_LAST,
		OUT_FLAG
	} out_sel_t;

	typedef struct packed {
		tbl_op_t  tbl_op;
		cur_op_t  cur_op;
		idx_op_t  idx_op;
		logic     path_clear;
		logic     path_mark;
		logic     head_ld;
		logic     rd_idx;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_flag;
	} dp_cmd_t;

	typedef struct packed {
		logic cur_in_range;
		logic cur_on_path;
		logic cur_valid;
		logic head_next;
		logic idx_valid;
		logic idx_last;
		logic valid_above;
		logic any_valid;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/wfcd_dp.sv
// ----------------------------------------------------------------------------
// wfcd_dp
// wait-for table, walk cursor, scan index, path marks and result register
// ----------------------------------------------------------------------------
`default_nettype none

module wfcd_dp #(
	parameter int NUM_PROCS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire wfcd_pkg::dp_cmd_t          cmd,
	output wfcd_pkg::dp_sts_t               sts,
	input  wire logic [wfcd_pkg::ID_W-1:0]  in_waiter,
	input  wire logic [wfcd_pkg::ID_W-1:0]  in_blocker,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [wfcd_pkg::ID_W-1:0]       out_node,
	output logic [wfcd_pkg::ID_W-1:0]       out_peer,
	output logic                            out_found,
	output logic                            out_empty,
	output logic                            out_last
);

	localparam int ID_SPAN = 1 << wfcd_pkg::ID_W;
	localparam int DEPTH   = (NUM_PROCS < ID_SPAN) ? NUM_PROCS : ID_SPAN;
	localparam int IW      = $clog2(DEPTH);
	localparam int CW      = wfcd_pkg::ID_W + 2;

	logic [DEPTH-1:0]            valid_q;
	logic [DEPTH-1:0]            on_path_q;
	logic [wfcd_pkg::ID_W-1:0]   target_q [DEPTH];
	logic [wfcd_pkg::ID_W-1:0]   cur_q;
	logic [wfcd_pkg::ID_W-1:0]   head_q;
	logic [IW-1:0]               idx_q;

	logic                        w_in_range;
	logic [IW-1:0]               w_idx;
	logic [IW-1:0]               cur_idx;
	logic [IW-1:0]               rd_addr;
	logic [wfcd_pkg::ID_W-1:0]   rd_target;
	logic                        above;
	logic                        out_free;

	assign w_in_range = (CW'(in_waiter) < CW'(NUM_PROCS));
	assign w_idx      = in_waiter[IW-1:0];
	assign cur_idx    = cur_q[IW-1:0];
	assign rd_addr    = cmd.rd_idx ? idx_q : cur_idx;
	assign rd_target  = target_q[rd_addr];
	assign out_free   = !out_valid || out_ready;

	// any valid edge above the scan index
	always_comb begin
		above = 1'b0;
		for (int j = 0; j < DEPTH; j++) begin
			if (valid_q[j] && (IW'(j) > idx_q))
				above = 1'b1;
		end
	end

	always_comb begin
		sts.cur_in_range = (CW'(cur_q) < CW'(NUM_PROCS));
		sts.cur_on_path  = sts.cur_in_range && on_path_q[cur_idx];
		sts.cur_valid    = sts.cur_in_range && valid_q[cur_idx];
		sts.head_next    = (rd_target == head_q);
		sts.idx_valid    = valid_q[idx_q];
		sts.idx_last     = (idx_q == IW'(DEPTH - 1));
		sts.valid_above  = above;
		sts.any_valid    = |valid_q;
		sts.out_free     = out_free;
	end

	// edge table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			unique case (cmd.tbl_op)
				wfcd_pkg::TBL_SET:  if (w_in_range) valid_q[w_idx] <= 1'b1;
				wfcd_pkg::TBL_CLR:  if (w_in_range) valid_q[w_idx] <= 1'b0;
				wfcd_pkg::TBL_WIPE: valid_q <= '0;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_op == wfcd_pkg::TBL_SET && w_in_range)
			target_q[w_idx] <= in_blocker;
	end

	// path marks of the current walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_path_q <= '0;
		end else if (cmd.path_clear) begin
			on_path_q <= '0;
		end else if (cmd.path_mark) begin
			on_path_q[cur_idx] <= 1'b1;
		end
	end

	// cursor, cycle head and scan index
	always_ff @(posedge clk) begin
		unique case (cmd.cur_op)
			wfcd_pkg::CUR_LOAD_IN:  cur_q <= in_waiter;
			wfcd_pkg::CUR_LOAD_IDX: cur_q <= wfcd_pkg::ID_W'(idx_q);
			wfcd_pkg::CUR_STEP:     cur_q <= rd_target;
			default:                ;
		endcase
		if (cmd.head_ld)
			head_q <= cur_q;
		unique case (cmd.idx_op)
			wfcd_pkg::IDX_ZERO: idx_q <= '0;
			wfcd_pkg::IDX_INC:  idx_q <= idx_q + IW'(1);
			default:            ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				wfcd_pkg::OUT_EDGE: begin
					out_node  <= wfcd_pkg::ID_W'(idx_q);
					out_peer  <= rd_target;
					out_found <= 1'b0;
					out_empty <= 1'b0;
					out_last  <= !above;
				end
				wfcd_pkg::OUT_MEMBER: begin
					out_node  <= cur_q;
					out_peer  <= '0;
					out_found <= 1'b1;
					out_empty <= 1'b0;
					out_last  <= 1'b0;
				end
				wfcd_pkg::OUT_HEAD_LAST: begin
					out_node  <= head_q;
					out_peer  <= '0;
					out_found <= 1'b1;
					out_empty <= 1'b0;
					out_last  <= 1'b1;
				end
				default: begin
					out_node  <= '0;
					out_peer  <= '0;
					out_found <= cmd.out_flag;
					out_empty <= 1'b1;
					out_last  <= 1'b1;
				end
			endcase
		end
	end

	a_wipe_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tbl_op == wfcd_pkg::TBL_WIPE |=> valid_q == '0)
		else $error("table not empty after clear");

	a_edge_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && cmd.out_sel == wfcd_pkg::OUT_EDGE |-> valid_q[idx_q])
		else $error("listed edge is not valid");

	a_mark_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.path_mark && !cmd.path_clear |-> !on_path_q[cur_idx])
		else $error("walk marked a node twice");

endmodule

`default_nettype wire

// File: rtl/core/wfcd_ctrl.sv
// ----------------------------------------------------------------------------
// wfcd_ctrl
// command sequencer of the wait-for cycle detector
// ----------------------------------------------------------------------------
`default_nettype none

module wfcd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         in_cmd,
	output wfcd_pkg::dp_cmd_t       cmd,
	input  wire wfcd_pkg::dp_sts_t  sts
);

	wfcd_pkg::state_t state_q, state_d;
	logic             flag_q, flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfcd_pkg::ST_IDLE;
			flag_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			flag_q  <= flag_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		flag_d         = flag_q;
		in_ready       = 1'b0;
		cmd.tbl_op     = wfcd_pkg::TBL_NONE;
		cmd.cur_op     = wfcd_pkg::CUR_HOLD;
		cmd.idx_op     = wfcd_pkg::IDX_HOLD;
		cmd.path_clear = 1'b0;
		cmd.path_mark  = 1'b0;
		cmd.head_ld    = 1'b0;
		cmd.rd_idx     = 1'b0;
		cmd.out_load   = 1'b0;
		cmd.out_sel    = wfcd_pkg::OUT_FLAG;
		cmd.out_flag   = flag_q;

		unique case (state_q)
			wfcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_cmd)
						wfcd_pkg::CMD_REG:   cmd.tbl_op = wfcd_pkg::TBL_SET;
						wfcd_pkg::CMD_UNREG: cmd.tbl_op = wfcd_pkg::TBL_CLR;
						wfcd_pkg::CMD_CLEAR: cmd.tbl_op = wfcd_pkg::TBL_WIPE;
						wfcd_pkg::CMD_LIST: begin
							cmd.idx_op = wfcd_pkg::IDX_ZERO;
							state_d    = wfcd_pkg::ST_LIST;
						end
						wfcd_pkg::CMD_FIND: begin
							cmd.cur_op     = wfcd_pkg::CUR_LOAD_IN;
							cmd.path_clear = 1'b1;
							state_d        = wfcd_pkg::ST_WALK;
						end
						wfcd_pkg::CMD_ANY: begin
							cmd.idx_op = wfcd_pkg::IDX_ZERO;
							state_d    = wfcd_pkg::ST_SCAN;
						end
						default: ;
					endcase
				end
			end

			wfcd_pkg::ST_LIST: begin
				cmd.rd_idx = 1'b1;
				if (!sts.any_valid) begin
					flag_d  = 1'b0;
					state_d = wfcd_pkg::ST_REPORT;
				end else if (!sts.idx_valid) begin
					cmd.idx_op = wfcd_pkg::IDX_INC;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = wfcd_pkg::OUT_EDGE;
					if (sts.valid_above)
						cmd.idx_op = wfcd_pkg::IDX_INC;
					else
						state_d = wfcd_pkg::ST_IDLE;
				end
			end

			wfcd_pkg::ST_WALK: begin
				priority if (sts.cur_on_path) begin
					cmd.head_ld = 1'b1;
					state_d     = wfcd_pkg::ST_EMIT;
				end else if (!sts.cur_valid) begin
					flag_d  = 1'b0;
					state_d = wfcd_pkg::ST_REPORT;
				end else begin
					cmd.path_mark = 1'b1;
					cmd.cur_op    = wfcd_pkg::CUR_STEP;
				end
			end

			wfcd_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = wfcd_pkg::OUT_MEMBER;
					cmd.cur_op   = wfcd_pkg::CUR_STEP;
					if (sts.head_next)
						state_d = wfcd_pkg::ST_EMIT_LAST;
				end
			end

			wfcd_pkg::ST_EMIT_LAST: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = wfcd_pkg::OUT_HEAD_LAST;
					state_d      = wfcd_pkg::ST_IDLE;
				end
			end

			wfcd_pkg::ST_SCAN: begin
				priority if (sts.idx_valid) begin
					cmd.cur_op     = wfcd_pkg::CUR_LOAD_IDX;
					cmd.path_clear = 1'b1;
					state_d        = wfcd_pkg::ST_DWALK;
				end else if (sts.idx_last) begin
					flag_d  = 1'b0;
					state_d = wfcd_pkg::ST_REPORT;
				end else begin
					cmd.idx_op = wfcd_pkg::IDX_INC;
				end
			end

			wfcd_pkg::ST_DWALK: begin
				priority if (sts.cur_on_path) begin
					flag_d  = 1'b1;
					state_d = wfcd_pkg::ST_REPORT;
				end else if (!sts.cur_valid) begin
					if (sts.idx_last) begin
						flag_d  = 1'b0;
						state_d = wfcd_pkg::ST_REPORT;
					end else begin
						cmd.idx_op = wfcd_pkg::IDX_INC;
						state_d    = wfcd_pkg::ST_SCAN;
					end
				end else begin
					cmd.path_mark = 1'b1;
					cmd.cur_op    = wfcd_pkg::CUR_STEP;
				end
			end

			wfcd_pkg::ST_REPORT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = wfcd_pkg::OUT_FLAG;
					state_d      = wfcd_pkg::ST_IDLE;
				end
			end

			default: state_d = wfcd_pkg::ST_IDLE;
		endcase
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	a_emit_on_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wfcd_pkg::ST_EMIT |-> sts.cur_valid)
		else $error("cycle emission left the cycle");

	a_list_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wfcd_pkg::ST_LIST && sts.any_valid && !sts.idx_valid
		|-> sts.valid_above)
		else $error("edge listing ran past the last edge");

endmodule

`default_nettype wire

// File: rtl/core/wait_for_cycle_detector.sv
// ----------------------------------------------------------------------------
// wait_for_cycle_detector
// wait-for table with edge listing, cycle search and deadlock query
// ----------------------------------------------------------------------------
// a command beat is taken only while the block is idle; the next waits until the block is idle again
// register, unregister, clear: done as the beat is taken, no result beat
// edge listing: one beat per valid edge in index order, a single empty beat if the table is empty
// cycle search: follows blocker links; on a hit one beat per cycle member, then the head as last
// deadlock query: scans the entries and walks from each valid one, one result beat
// a stalled result beat holds the sequencer; reset clears valid bits and path marks
// ----------------------------------------------------------------------------
`default_nettype none

module wait_for_cycle_detector #(
	parameter int NUM_PROCS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// command stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [4:0] waiter, [9:5] blocker, rest zero
	input  wire logic [2:0]  s_tuser,  // [2:0] cmd

	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [4:0] node, [9:5] peer, rest zero
	output logic [1:0]       m_tuser,  // [0] found, [1] empty_res
	output logic             m_tlast
);

	wfcd_pkg::dp_cmd_t           dp_cmd;
	wfcd_pkg::dp_sts_t           dp_sts;
	logic [wfcd_pkg::ID_W-1:0]   out_node;
	logic [wfcd_pkg::ID_W-1:0]   out_peer;
	logic                        out_found;
	logic                        out_empty;

	// sequencer: accepts a beat only when idle, walks and scans step by step
	wfcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.cmd      (dp_cmd),
		.sts      (dp_sts)
	);

	// table, walk state and result register
	wfcd_dp #(
		.NUM_PROCS (NUM_PROCS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.sts        (dp_sts),
		.in_waiter  (s_tdata[4:0]),
		.in_blocker (s_tdata[9:5]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_node   (out_node),
		.out_peer   (out_peer),
		.out_found  (out_found),
		.out_empty  (out_empty),
		.out_last   (m_tlast)
	);

	// pack result fields, lowest field first
	assign m_tdata = {6'd0, out_peer, out_node};
	assign m_tuser = {out_empty, out_found};

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the wait-for cycle detector: a directed table, then
// random commands and ring-building sequences, each scored beat by beat
// against an in-bench model of the wait-for table
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int NPROC        = 32;
	localparam int PERIOD       = 8;
	localparam int RAND_ITEMS   = 225;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 3_000_000;

	// codes outside the command set, the block must drop them silently
	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	// one result beat as the model sees it
	typedef struct packed {
		logic [4:0] node;
		logic [4:0] peer;
		logic       found;
		logic       empty_res;
		logic       last;
	} res_t;

	// one row of the directed table
	typedef struct packed {
		logic [2:0] cmd;
		logic [4:0] waiter;
		logic [4:0] blocker;
		logic       pinned;   // expected beat typed in the row
		res_t       want;
	} stim_row_t;

	localparam bit   PINNED    = 1'b1;
	localparam bit   PREDICTED = 1'b0;
	localparam res_t NONE_BEAT     = '0;
	// empty listing, search miss and "no deadlock" all look the same
	localparam res_t NO_HIT_BEAT   = {5'd0, 5'd0, 1'b0, 1'b1, 1'b1};
	localparam res_t DEADLOCK_BEAT = {5'd0, 5'd0, 1'b1, 1'b1, 1'b1};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// wait-for table mirror
	logic       link_ok [NPROC];
	logic [4:0] link_to [NPROC];

	// path of the latest walk
	logic [4:0] trail [NPROC+2];
	int         trail_len;
	int         hit_pos;

	res_t       expected_beats [$];
	res_t       want_beat;
	stim_row_t  plan [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cmds_sent   = 0;
	int fail_count  = 0;
	int cycle_count = 0;

	always #(PERIOD/2) clk = ~clk;

	wait_for_cycle_detector #(
		.NUM_PROCS(NPROC)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [4:0] waiter, [9:5] blocker, rest zero
		.s_tuser  (s_tuser),   // [2:0] cmd
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [4:0] node, [9:5] peer, rest zero
		.m_tuser  (m_tuser),   // [0] found, [1] empty_res
		.m_tlast  (m_tlast)
	);

	// ------------------------------------------------------------------------
	// table model
	// ------------------------------------------------------------------------

	function automatic logic [4:0] rnd_id();
		return 5'($urandom_range(0, 31));
	endfunction

	// append to the tail of the expectation queue
	function automatic void queue_beat(input res_t b);
		expected_beats = {expected_beats, b};
	endfunction

	// append to the tail of the directed table
	function automatic void add_row(input stim_row_t r);
		plan = {plan, r};
	endfunction

	function automatic res_t mk_beat(input logic [4:0] node, input logic [4:0] peer,
	                                 input logic found, input logic empty_res,
	                                 input logic last);
		res_t r;
		r.node      = node;
		r.peer      = peer;
		r.found     = found;
		r.empty_res = empty_res;
		r.last      = last;
		return r;
	endfunction

	// follow blocker links from start until an id repeats (hit) or has no edge
	function automatic bit trace_cycle(input logic [4:0] start);
		bit seen [NPROC];
		int cur;
		int i;
		for (int k = 0; k < NPROC; k++) seen[k] = 1'b0;
		cur       = start;
		trail_len = 0;
		hit_pos   = 0;
		forever begin
			if (cur < NPROC && seen[cur]) begin
				i = 0;
				while (i < trail_len && trail[i] != cur) i++;
				hit_pos = i;
				return 1'b1;
			end
			if (trail_len > NPROC) return 1'b0;
			trail[trail_len] = cur[4:0];
			trail_len++;
			// ids beyond the table end the walk like a missing edge
			if (cur >= NPROC || !link_ok[cur]) return 1'b0;
			seen[cur] = 1'b1;
			cur = link_to[cur];
		end
	endfunction

	// update the mirror for one accepted command and queue the beats it causes
	task automatic predict_beats(input logic [2:0] cmd, input logic [4:0] w,
	                             input logic [4:0] b);
		int  top;
		bit  any;
		unique case (cmd)
			wfcd_pkg::CMD_REG: begin
				if (w < NPROC) begin
					link_ok[w] = 1'b1;
					link_to[w] = b;
				end
			end
			wfcd_pkg::CMD_UNREG: begin
				if (w < NPROC) link_ok[w] = 1'b0;
			end
			wfcd_pkg::CMD_CLEAR: begin
				for (int i = 0; i < NPROC; i++) link_ok[i] = 1'b0;
			end
			wfcd_pkg::CMD_LIST: begin
				top = -1;
				for (int i = 0; i < NPROC; i++) if (link_ok[i]) top = i;
				if (top < 0) begin
					queue_beat(NO_HIT_BEAT);
				end else begin
					for (int i = 0; i <= top; i++) begin
						if (link_ok[i])
							queue_beat(mk_beat(i[4:0], link_to[i],
								1'b0, 1'b0, i == top));
					end
				end
			end
			wfcd_pkg::CMD_FIND: begin
				if (trace_cycle(w)) begin
					// members from the repeated id on, then that id again as last
					for (int i = hit_pos; i < trail_len; i++)
						queue_beat(mk_beat(trail[i], 5'd0, 1'b1, 1'b0, 1'b0));
					queue_beat(mk_beat(trail[hit_pos], 5'd0, 1'b1, 1'b0, 1'b1));
				end else begin
					queue_beat(NO_HIT_BEAT);
				end
			end
			wfcd_pkg::CMD_ANY: begin
				any = 1'b0;
				for (int i = 0; i < NPROC && !any; i++)
					if (link_ok[i] && trace_cycle(i[4:0])) any = 1'b1;
				queue_beat(any ? DEADLOCK_BEAT : NO_HIT_BEAT);
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------------

	// one command beat: random idle gap, hold until accepted, then predict
	task automatic send_cmd(input logic [2:0] cmd, input logic [4:0] w, input logic [4:0] b,
	                        input bit pinned, input res_t want);
		int n0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'd0, b, w};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// accepted at this edge
		n0 = expected_beats.size();
		predict_beats(cmd, w, b);
		if (pinned) begin
			// the row carries its own expectation, the model only keeps state
			while (expected_beats.size() > n0) void'(expected_beats.pop_back());
			queue_beat(want);
		end
		// dropped codes do not count as stimulus
		if (cmd <= wfcd_pkg::CMD_ANY) cmds_sent++;
	endtask

	// random command with random ids
	task automatic random_cmd();
		int         pick;
		logic [2:0] c;
		logic [4:0] w;
		pick = $urandom_range(0, 99);
		w    = rnd_id();
		if (pick < 35)      c = wfcd_pkg::CMD_REG;
		else if (pick < 45) c = wfcd_pkg::CMD_UNREG;
		else if (pick < 48) c = wfcd_pkg::CMD_CLEAR;
		else if (pick < 60) c = wfcd_pkg::CMD_LIST;
		else if (pick < 82) c = wfcd_pkg::CMD_FIND;
		else if (pick < 92) c = wfcd_pkg::CMD_ANY;
		else if (pick < 96) c = wfcd_pkg::CMD_REG;   // paired with a self loop below
		else                c = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
		send_cmd(c, w, (pick >= 92 && pick < 96) ? w : rnd_id(), PREDICTED, NONE_BEAT);
	endtask

	// well-formed sequence: build a ring over shuffled ids, maybe a tail into it,
	// maybe break it again, then search from somewhere on or near it
	task automatic build_ring();
		logic [4:0] ids [NPROC];
		logic [4:0] tmp;
		int         len;
		int         j;
		for (int i = 0; i < NPROC; i++) ids[i] = i[4:0];
		for (int i = NPROC - 1; i > 0; i--) begin
			j      = $urandom_range(0, i);
			tmp    = ids[i];
			ids[i] = ids[j];
			ids[j] = tmp;
		end
		// mostly short rings, now and then one through every id
		len = ($urandom_range(0, 7) == 0) ? NPROC : $urandom_range(1, 8);
		if ($urandom_range(0, 1))
			send_cmd(wfcd_pkg::CMD_CLEAR, rnd_id(), rnd_id(), PREDICTED, NONE_BEAT);
		for (int i = 0; i < len; i++)
			send_cmd(wfcd_pkg::CMD_REG, ids[i], ids[(i + 1) % len], PREDICTED, NONE_BEAT);
		if (len < NPROC && $urandom_range(0, 1))
			send_cmd(wfcd_pkg::CMD_REG, ids[len], ids[$urandom_range(0, len - 1)],
				PREDICTED, NONE_BEAT);
		if ($urandom_range(0, 3) == 0)
			send_cmd(wfcd_pkg::CMD_UNREG, ids[$urandom_range(0, len - 1)], rnd_id(),
				PREDICTED, NONE_BEAT);
		send_cmd(wfcd_pkg::CMD_FIND, ids[$urandom_range(0, (len < NPROC) ? len : NPROC - 1)],
			rnd_id(), PREDICTED, NONE_BEAT);
		if ($urandom_range(0, 1))
			send_cmd(wfcd_pkg::CMD_ANY, rnd_id(), rnd_id(), PREDICTED, NONE_BEAT);
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// receiver stalls at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	task automatic check_field(input string field, input logic [15:0] exp_v,
	                           input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
			fail_count++;
		end
	endtask

	// score every accepted result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected: node %0d peer %0d tlast %0d",
					m_tdata[4:0], m_tdata[9:5], m_tlast);
				fail_count++;
			end else begin
				want_beat = expected_beats.pop_front();
				check_field("node",      want_beat.node,      m_tdata[4:0]);
				check_field("peer",      want_beat.peer,      m_tdata[9:5]);
				check_field("tdata pad", 16'd0,               m_tdata[15:10]);
				check_field("found",     want_beat.found,     m_tuser[0]);
				check_field("empty_res", want_beat.empty_res, m_tuser[1]);
				check_field("last",      want_beat.last,      m_tlast);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL wait_for_cycle_detector");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		stim_row_t row;
		int        base;
		int        target;

		for (int i = 0; i < NPROC; i++) begin
			link_ok[i] = 1'b0;
			link_to[i] = 5'd0;
		end

		// after reset the table is empty
		add_row({wfcd_pkg::CMD_LIST,  5'd0,  5'd0,  PINNED,    NO_HIT_BEAT});
		add_row({wfcd_pkg::CMD_FIND,  5'd0,  5'd0,  PINNED,    NO_HIT_BEAT});
		add_row({wfcd_pkg::CMD_ANY,   5'd31, 5'd31, PINNED,    NO_HIT_BEAT});
		// two-member cycle between the lowest and highest id
		add_row({wfcd_pkg::CMD_REG,   5'd0,  5'd31, PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_REG,   5'd31, 5'd0,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_LIST,  5'd0,  5'd0,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_FIND,  5'd31, 5'd0,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_ANY,   5'd0,  5'd0,  PINNED,    DEADLOCK_BEAT});
		// process waiting on itself
		add_row({wfcd_pkg::CMD_REG,   5'd21, 5'd21, PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_FIND,  5'd21, 5'd10, PREDICTED, NONE_BEAT});
		// overwrite an edge, the walk now dead-ends on a process with no edge
		add_row({wfcd_pkg::CMD_REG,   5'd0,  5'd10, PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_FIND,  5'd31, 5'd0,  PREDICTED, NONE_BEAT});
		// tail leading into a cycle, only the cycle part is reported
		add_row({wfcd_pkg::CMD_REG,   5'd1,  5'd2,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_REG,   5'd2,  5'd3,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_REG,   5'd3,  5'd2,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_FIND,  5'd1,  5'd0,  PREDICTED, NONE_BEAT});
		// remove an edge, and remove one that is not there
		add_row({wfcd_pkg::CMD_UNREG, 5'd21, 5'd21, PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_UNREG, 5'd30, 5'd0,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_FIND,  5'd21, 5'd0,  PREDICTED, NONE_BEAT});
		// codes outside the set leave the table alone
		add_row({CMD_UNUSED_6,        5'd4,  5'd5,  PREDICTED, NONE_BEAT});
		add_row({CMD_UNUSED_7,        5'd31, 5'd31, PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_LIST,  5'd0,  5'd0,  PREDICTED, NONE_BEAT});
		// clear wipes every edge
		add_row({wfcd_pkg::CMD_CLEAR, 5'd0,  5'd0,  PREDICTED, NONE_BEAT});
		add_row({wfcd_pkg::CMD_LIST,  5'd0,  5'd0,  PINNED,    NO_HIT_BEAT});
		add_row({wfcd_pkg::CMD_ANY,   5'd0,  5'd0,  PINNED,    NO_HIT_BEAT});

		// reset once, at the start
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under a busy receiver
		tx_idle_pct = 11;
		rx_idle_pct = 73;
		foreach (plan[r]) begin
			row = plan[r];
			send_cmd(row.cmd, row.waiter, row.blocker, row.pinned, row.want);
		end

		// random part in three idling phases
		base = cmds_sent;
		for (int phase = 0; phase < 3; phase++) begin
			unique case (phase)
				0: begin tx_idle_pct = 11; rx_idle_pct = 73; end
				1: begin tx_idle_pct = 73; rx_idle_pct = 11; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			target = base + (phase + 1) * RAND_ITEMS / 3;
			while (cmds_sent < target) begin
				if ($urandom_range(0, 4) == 0) build_ring();
				else random_cmd();
			end
		end
		s_tvalid <= 1'b0;

		// drain, then give stray beats a chance to show up
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("PASS wait_for_cycle_detector");
		end else begin
			$display("FAIL wait_for_cycle_detector");
		end
		$finish;
	end

endmodule

`default_nettype wire
